@@ rtl/bnfa_pkg.sv @@
// ----------------------------------------------------------------------------
// Bitmap next-fit allocator package
// Shared widths, request and result types, status codes and map commands.
// ----------------------------------------------------------------------------
package bnfa_pkg;

  // Pool geometry. Slot indexes are 6 bits wide, so the map holds 64 slots.
  localparam int SLOTS       = 64;
  localparam int IDX_W       = 6;
  localparam int CNT_W       = 7;
  localparam int CHUNK_W     = 8;
  localparam int CHUNK_SEL_W = 3;
  localparam int OFF_W       = 3;

  // Request kinds.
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_BAD_FREE = 2'd2
  } status_t;

  // One request as it enters the block.
  typedef struct packed {
    logic             req_type;
    logic [IDX_W-1:0] slot_index;
  } request_t;

  // One result as it leaves the block.
  typedef struct packed {
    logic [IDX_W-1:0] granted_slot;
    status_t          status;
    logic [CNT_W-1:0] free_slots;
  } result_t;

  // Update command for the used map.
  typedef struct packed {
    logic             init;
    logic             set;
    logic             clr;
    logic [IDX_W-1:0] idx;
  } map_cmd_t;

  // Clamp a written pool size into the range 1 to SLOTS.
  function automatic logic [CNT_W-1:0] eff_size(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] s;
    s = v;
    if (v == '0) begin
      s = CNT_W'(1);
    end else if (v > CNT_W'(SLOTS)) begin
      s = CNT_W'(SLOTS);
    end
    return s;
  endfunction

endpackage

@@ rtl/bnfa_map.sv @@
// ----------------------------------------------------------------------------
// Used-slot map
// One flip-flop per slot with set, clear and clear-all, an aligned 8-slot
// chunk read port for the scan and a single-bit read port for free checks.
// ----------------------------------------------------------------------------
module bnfa_map
  import bnfa_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  map_cmd_t               cmd,
  input  logic [CHUNK_SEL_W-1:0] chunk_sel,
  output logic [CHUNK_W-1:0]     chunk_bits,
  input  logic [IDX_W-1:0]       bit_idx,
  output logic                   bit_used
);

  logic [SLOTS-1:0] used;

  // Map update: clear-all wins over single-bit changes.
  always_ff @(posedge clk) begin
    if (rst || cmd.init) begin
      used <= '0;
    end else if (cmd.set) begin
      used[cmd.idx] <= 1'b1;
    end else if (cmd.clr) begin
      used[cmd.idx] <= 1'b0;
    end
  end

  // Read ports.
  assign chunk_bits = used[{chunk_sel, {OFF_W{1'b0}}} +: CHUNK_W];
  assign bit_used   = used[bit_idx];

endmodule

@@ rtl/bnfa_scan.sv @@
// ----------------------------------------------------------------------------
// Chunk scan unit
// Finds the lowest free slot in one 8-slot chunk, at or above a start offset
// and below the pool size.
// ----------------------------------------------------------------------------
module bnfa_scan
  import bnfa_pkg::*;
(
  input  logic [CHUNK_W-1:0]     chunk_bits,
  input  logic [CHUNK_SEL_W-1:0] chunk_sel,
  input  logic [OFF_W-1:0]       lo,
  input  logic [CNT_W-1:0]       size,
  output logic                   found,
  output logic [OFF_W-1:0]       off
);

  logic [CHUNK_W-1:0] cand;

  // A slot is a candidate when it is free, not below the start and in the pool.
  always_comb begin
    for (int j = 0; j < CHUNK_W; j++) begin
      cand[j] = !chunk_bits[j] && (OFF_W'(j) >= lo) &&
                ({1'b0, chunk_sel, OFF_W'(j)} < size);
    end
  end

  // Priority encode toward the lowest index.
  always_comb begin
    found = 1'b0;
    off   = '0;
    for (int j = CHUNK_W - 1; j >= 0; j--) begin
      if (cand[j]) begin
        found = 1'b1;
        off   = OFF_W'(j);
      end
    end
  end

endmodule

@@ rtl/bitmap_next_fit_allocator.sv @@
// ----------------------------------------------------------------------------
// Bitmap next-fit slot allocator
// Allocates and frees slots of a fixed pool tracked by a used-bit map, a
// next-fit hint and a free count, one request at a time.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its one result shows
// on result for exactly one cycle, marked by done, and must be taken then.
// A free request gives its result in the cycle after it is taken and leaves
// busy low, so requests may follow each other every cycle. An allocate
// request raises busy while one shared chunk scanner walks the used map eight
// slots per cycle from the hint, wrapping at the pool size, with done in the
// cycle after the free slot is found. A full pool answers in the next cycle.
// Writing pool_size (0 acts as 1, above 64 acts as 64) frees every slot and
// must happen only while no request is outstanding.
module bitmap_next_fit_allocator
  import bnfa_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             pool_size_we,
  input  logic [CNT_W-1:0] pool_size_data,
  input  logic             start,
  input  request_t         request,
  output logic             busy,
  output logic             done,
  output result_t          result
);

  typedef enum logic {
    IDLE,
    SCAN
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] pool_size;
  logic [CNT_W-1:0] free_count;
  logic [IDX_W-1:0] next_hint;
  logic [IDX_W-1:0] pos;

  map_cmd_t               map_cmd;
  logic [CHUNK_W-1:0]     chunk_bits;
  logic                   bit_used;
  logic                   found;
  logic [OFF_W-1:0]       off;
  logic                   accept;
  logic                   free_ok;
  logic [IDX_W-1:0]       found_slot;
  logic [CNT_W-1:0]       slot_plus;
  logic [CNT_W-1:0]       chunk_end;

  assign busy   = (state == SCAN);
  assign accept = start && !busy;

  // Used map and the shared chunk scanner.
  bnfa_map u_map (
    .clk       (clk),
    .rst       (rst),
    .cmd       (map_cmd),
    .chunk_sel (pos[IDX_W-1:OFF_W]),
    .chunk_bits(chunk_bits),
    .bit_idx   (request.slot_index),
    .bit_used  (bit_used)
  );

  bnfa_scan u_scan (
    .chunk_bits(chunk_bits),
    .chunk_sel (pos[IDX_W-1:OFF_W]),
    .lo        (pos[OFF_W-1:0]),
    .size      (pool_size),
    .found     (found),
    .off       (off)
  );

  // Scan arithmetic: slot found, hint after it, and start of the next chunk.
  assign found_slot = {pos[IDX_W-1:OFF_W], off};
  assign slot_plus  = {1'b0, found_slot} + CNT_W'(1);
  assign chunk_end  = {1'b0, pos[IDX_W-1:OFF_W], {OFF_W{1'b0}}} + CNT_W'(CHUNK_W);

  // A free is valid when the slot is inside the pool and currently used.
  assign free_ok = ({1'b0, request.slot_index} < pool_size) && bit_used;

  // Map updates from the sequencer and from configuration writes.
  always_comb begin
    map_cmd.init = pool_size_we;
    map_cmd.set  = (state == SCAN) && found;
    map_cmd.clr  = (state == IDLE) && accept && (request.req_type == REQ_FREE) && free_ok;
    map_cmd.idx  = (state == SCAN) ? found_slot : request.slot_index;
  end

  // Sequencer, pool state and registered result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      pool_size  <= CNT_W'(SLOTS);
      free_count <= CNT_W'(SLOTS);
      next_hint  <= '0;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        IDLE: begin
          if (accept) begin
            if (request.req_type == REQ_FREE) begin
              result.granted_slot <= '0;
              done                <= 1'b1;
              if (free_ok) begin
                result.status     <= ST_OK;
                result.free_slots <= free_count + CNT_W'(1);
                free_count        <= free_count + CNT_W'(1);
                next_hint         <= request.slot_index;
              end else begin
                result.status     <= ST_BAD_FREE;
                result.free_slots <= free_count;
              end
            end else if (free_count == '0) begin
              result.granted_slot <= '0;
              result.status       <= ST_FULL;
              result.free_slots   <= free_count;
              done                <= 1'b1;
            end else begin
              pos   <= ({1'b0, next_hint} < pool_size) ? next_hint : '0;
              state <= SCAN;
            end
          end
        end
        SCAN: begin
          if (found) begin
            result.granted_slot <= found_slot;
            result.status       <= ST_OK;
            result.free_slots   <= free_count - CNT_W'(1);
            free_count          <= free_count - CNT_W'(1);
            next_hint           <= (slot_plus >= pool_size) ? '0 : slot_plus[IDX_W-1:0];
            done                <= 1'b1;
            state               <= IDLE;
          end else begin
            pos <= (chunk_end >= pool_size) ? '0 : chunk_end[IDX_W-1:0];
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase

      // A pool size write reinitializes the pool.
      if (pool_size_we) begin
        pool_size  <= eff_size(pool_size_data);
        free_count <= eff_size(pool_size_data);
        next_hint  <= '0;
      end
    end
  end

`ifndef ASSERT_OFF
  // A result is never presented while an allocation scan is still running.
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while scan busy");

  // A free request always answers in the next cycle.
  a_free_latency: assert property (@(posedge clk) disable iff (rst)
    (accept && request.req_type == REQ_FREE) |=> done)
    else $error("free request gave no result in the next cycle");

  // The free count never exceeds the pool size.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    free_count <= pool_size)
    else $error("free count above pool size");
`endif

endmodule
